FILE: rtl/wtlf_pkg.sv
// Shared types, constants and helpers for the weighted time line fitter.
// Holds the micro-op encoding, the sequencer program and the saturation functions.
// No dependencies.
`timescale 1ns / 1ps

package wtlf_pkg;

    localparam int VW   = 128;
    localparam int PC_W = 7;

    typedef logic signed [VW-1:0] wide_t;
    typedef logic [PC_W-1:0]      pc_t;

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_TIME    = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    localparam logic CFG_DECAY  = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    localparam pc_t PC_OBS      = 7'd0;
    localparam pc_t PC_DECAY    = 7'd13;
    localparam pc_t PC_OBS_END  = 7'd61;
    localparam pc_t PC_QUERY    = 7'd62;
    localparam pc_t PC_SAMPLE   = 7'd89;
    localparam pc_t PC_NOFIT    = 7'd96;

    typedef enum logic [4:0] {
        OP_PASS, OP_ADD, OP_SUB, OP_SHLF, OP_SARF, OP_SAR16, OP_SHL1,
        OP_SAT32, OP_SAT64, OP_MUL, OP_DIV, OP_CNTINC, OP_CNTCLR,
        OP_BRZ, OP_BRNZ, OP_BRLT, OP_BRSAMP, OP_END, OP_END_RES, OP_END_NOFIT
    } op_t;

    typedef enum logic [4:0] {
        S_ZERO, S_W, S_SX, S_ST, S_SXX, S_SXT, S_XV, S_YV, S_DR, S_ONE,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_P, S_Q
    } src_t;

    typedef enum logic [3:0] {
        D_NONE, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_W, D_SX, D_ST,
        D_SXX, D_SXT, D_OX, D_OT, D_TR, D_SR
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t dst;
        pc_t  tgt;
    } uword_t;

    typedef struct packed {
        logic   exec;
        logic   in_load;
        uword_t uw;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic cnt_lt;
        logic sample_q;
        logic unit_done;
    } stat_t;

    function automatic logic signed [63:0] sat64(wide_t a);
        logic fits;
        fits = (&a[VW-1:63]) || !(|a[VW-1:63]);
        if (fits)
            return a[63:0];
        return a[VW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic signed [47:0] sat48(wide_t a);
        logic fits;
        fits = (&a[VW-1:47]) || !(|a[VW-1:47]);
        if (fits)
            return a[47:0];
        return a[VW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(wide_t a);
        logic fits;
        fits = (&a[VW-1:31]) || !(|a[VW-1:31]);
        if (fits)
            return a[31:0];
        return a[VW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic [31:0] satu32(wide_t a);
        if (a[VW-1])
            return 32'd0;
        if (|a[VW-1:32])
            return {32{1'b1}};
        return a[31:0];
    endfunction

    function automatic uword_t mk(op_t op, src_t a, src_t b, dst_t d, pc_t t);
        uword_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = d;
        u.tgt = t;
        return u;
    endfunction

    // Sequencer program: observe from PC_OBS, both queries from PC_QUERY
    function automatic uword_t ucode(pc_t pc);
        uword_t u;
        case (pc)
            // observe: scaled pair terms
            7'd0:  u = mk(OP_SHLF,   S_XV,  S_ZERO, D_T0,  '0);
            7'd1:  u = mk(OP_SHLF,   S_YV,  S_ZERO, D_T1,  '0);
            7'd2:  u = mk(OP_MUL,    S_XV,  S_XV,   D_NONE, '0);
            7'd3:  u = mk(OP_SHLF,   S_P,   S_ZERO, D_T2,  '0);
            7'd4:  u = mk(OP_MUL,    S_XV,  S_YV,   D_NONE, '0);
            7'd5:  u = mk(OP_SHLF,   S_P,   S_ZERO, D_T3,  '0);
            7'd6:  u = mk(OP_BRNZ,   S_W,   S_ZERO, D_NONE, PC_DECAY);
            // first pair seeds the sums
            7'd7:  u = mk(OP_PASS,   S_T0,  S_ZERO, D_SX,  '0);
            7'd8:  u = mk(OP_PASS,   S_T1,  S_ZERO, D_ST,  '0);
            7'd9:  u = mk(OP_PASS,   S_T2,  S_ZERO, D_SXX, '0);
            7'd10: u = mk(OP_PASS,   S_T3,  S_ZERO, D_SXT, '0);
            7'd11: u = mk(OP_PASS,   S_ONE, S_ZERO, D_W,   '0);
            7'd12: u = mk(OP_END,    S_ZERO, S_ZERO, D_NONE, '0);
            // decay and accumulate
            7'd13: u = mk(OP_MUL,    S_SX,  S_DR,   D_NONE, '0);
            7'd14: u = mk(OP_SAR16,  S_P,   S_ZERO, D_T4,  '0);
            7'd15: u = mk(OP_SUB,    S_SX,  S_T4,   D_T4,  '0);
            7'd16: u = mk(OP_ADD,    S_T4,  S_T0,   D_SX,  '0);
            7'd17: u = mk(OP_MUL,    S_ST,  S_DR,   D_NONE, '0);
            7'd18: u = mk(OP_SAR16,  S_P,   S_ZERO, D_T4,  '0);
            7'd19: u = mk(OP_SUB,    S_ST,  S_T4,   D_T4,  '0);
            7'd20: u = mk(OP_ADD,    S_T4,  S_T1,   D_ST,  '0);
            7'd21: u = mk(OP_MUL,    S_SXX, S_DR,   D_NONE, '0);
            7'd22: u = mk(OP_SAR16,  S_P,   S_ZERO, D_T4,  '0);
            7'd23: u = mk(OP_SUB,    S_SXX, S_T4,   D_T4,  '0);
            7'd24: u = mk(OP_ADD,    S_T4,  S_T2,   D_SXX, '0);
            7'd25: u = mk(OP_MUL,    S_SXT, S_DR,   D_NONE, '0);
            7'd26: u = mk(OP_SAR16,  S_P,   S_ZERO, D_T4,  '0);
            7'd27: u = mk(OP_SUB,    S_SXT, S_T4,   D_T4,  '0);
            7'd28: u = mk(OP_ADD,    S_T4,  S_T3,   D_SXT, '0);
            7'd29: u = mk(OP_MUL,    S_W,   S_DR,   D_NONE, '0);
            7'd30: u = mk(OP_SAR16,  S_P,   S_ZERO, D_T4,  '0);
            7'd31: u = mk(OP_SUB,    S_W,   S_T4,   D_T4,  '0);
            7'd32: u = mk(OP_ADD,    S_T4,  S_ONE,  D_W,   '0);
            7'd33: u = mk(OP_CNTINC, S_ZERO, S_ZERO, D_NONE, '0);
            7'd34: u = mk(OP_BRLT,   S_ZERO, S_ZERO, D_NONE, PC_OBS_END);
            // move the origin to the weighted mean
            7'd35: u = mk(OP_CNTCLR, S_ZERO, S_ZERO, D_NONE, '0);
            7'd36: u = mk(OP_DIV,    S_SX,  S_W,    D_NONE, '0);
            7'd37: u = mk(OP_SAT32,  S_Q,   S_ZERO, D_T0,  '0);
            7'd38: u = mk(OP_DIV,    S_ST,  S_W,    D_NONE, '0);
            7'd39: u = mk(OP_SAT32,  S_Q,   S_ZERO, D_T1,  '0);
            7'd40: u = mk(OP_MUL,    S_T0,  S_W,    D_NONE, '0);
            7'd41: u = mk(OP_SUB,    S_SX,  S_P,    D_T2,  '0);
            7'd42: u = mk(OP_MUL,    S_T1,  S_W,    D_NONE, '0);
            7'd43: u = mk(OP_SUB,    S_ST,  S_P,    D_T3,  '0);
            7'd44: u = mk(OP_MUL,    S_T0,  S_SX,   D_NONE, '0);
            7'd45: u = mk(OP_SHL1,   S_P,   S_ZERO, D_T4,  '0);
            7'd46: u = mk(OP_SUB,    S_SXX, S_T4,   D_T4,  '0);
            7'd47: u = mk(OP_MUL,    S_T0,  S_T0,   D_NONE, '0);
            7'd48: u = mk(OP_MUL,    S_P,   S_W,    D_NONE, '0);
            7'd49: u = mk(OP_ADD,    S_T4,  S_P,    D_SXX, '0);
            7'd50: u = mk(OP_MUL,    S_T1,  S_SX,   D_NONE, '0);
            7'd51: u = mk(OP_SUB,    S_SXT, S_P,    D_T4,  '0);
            7'd52: u = mk(OP_MUL,    S_T0,  S_ST,   D_NONE, '0);
            7'd53: u = mk(OP_SUB,    S_T4,  S_P,    D_T4,  '0);
            7'd54: u = mk(OP_MUL,    S_T0,  S_T1,   D_NONE, '0);
            7'd55: u = mk(OP_MUL,    S_P,   S_W,    D_NONE, '0);
            7'd56: u = mk(OP_ADD,    S_T4,  S_P,    D_SXT, '0);
            7'd57: u = mk(OP_PASS,   S_T2,  S_ZERO, D_SX,  '0);
            7'd58: u = mk(OP_PASS,   S_T3,  S_ZERO, D_ST,  '0);
            7'd59: u = mk(OP_PASS,   S_T0,  S_ZERO, D_OX,  '0);
            7'd60: u = mk(OP_PASS,   S_T1,  S_ZERO, D_OT,  '0);
            7'd61: u = mk(OP_END,    S_ZERO, S_ZERO, D_NONE, '0);
            // queries: fit the line
            7'd62: u = mk(OP_BRZ,    S_W,   S_ZERO, D_NONE, PC_NOFIT);
            7'd63: u = mk(OP_MUL,    S_W,   S_SXT,  D_NONE, '0);
            7'd64: u = mk(OP_PASS,   S_P,   S_ZERO, D_T0,  '0);
            7'd65: u = mk(OP_MUL,    S_SX,  S_ST,   D_NONE, '0);
            7'd66: u = mk(OP_SUB,    S_T0,  S_P,    D_T0,  '0);
            7'd67: u = mk(OP_MUL,    S_W,   S_SXX,  D_NONE, '0);
            7'd68: u = mk(OP_PASS,   S_P,   S_ZERO, D_T1,  '0);
            7'd69: u = mk(OP_MUL,    S_SX,  S_SX,   D_NONE, '0);
            7'd70: u = mk(OP_SUB,    S_T1,  S_P,    D_T1,  '0);
            7'd71: u = mk(OP_BRZ,    S_T1,  S_ZERO, D_NONE, PC_NOFIT);
            7'd72: u = mk(OP_SHLF,   S_T0,  S_ZERO, D_T0,  '0);
            7'd73: u = mk(OP_DIV,    S_T0,  S_T1,   D_NONE, '0);
            7'd74: u = mk(OP_SAT64,  S_Q,   S_ZERO, D_T2,  '0);
            7'd75: u = mk(OP_SHLF,   S_SX,  S_ZERO, D_T3,  '0);
            7'd76: u = mk(OP_DIV,    S_T3,  S_W,    D_NONE, '0);
            7'd77: u = mk(OP_SAT64,  S_Q,   S_ZERO, D_T3,  '0);
            7'd78: u = mk(OP_SHLF,   S_ST,  S_ZERO, D_T4,  '0);
            7'd79: u = mk(OP_DIV,    S_T4,  S_W,    D_NONE, '0);
            7'd80: u = mk(OP_SAT64,  S_Q,   S_ZERO, D_T4,  '0);
            7'd81: u = mk(OP_BRSAMP, S_ZERO, S_ZERO, D_NONE, PC_SAMPLE);
            // time for sample
            7'd82: u = mk(OP_SHLF,   S_XV,  S_ZERO, D_T5,  '0);
            7'd83: u = mk(OP_SUB,    S_T5,  S_T3,   D_T5,  '0);
            7'd84: u = mk(OP_SAT64,  S_T5,  S_ZERO, D_T5,  '0);
            7'd85: u = mk(OP_MUL,    S_T2,  S_T5,   D_NONE, '0);
            7'd86: u = mk(OP_SARF,   S_P,   S_ZERO, D_T5,  '0);
            7'd87: u = mk(OP_ADD,    S_T5,  S_T4,   D_TR,  '0);
            7'd88: u = mk(OP_END_RES, S_ZERO, S_ZERO, D_NONE, '0);
            // sample for time
            7'd89: u = mk(OP_BRZ,    S_T2,  S_ZERO, D_NONE, PC_NOFIT);
            7'd90: u = mk(OP_SHLF,   S_YV,  S_ZERO, D_T5,  '0);
            7'd91: u = mk(OP_SUB,    S_T5,  S_T4,   D_T5,  '0);
            7'd92: u = mk(OP_SHLF,   S_T5,  S_ZERO, D_T5,  '0);
            7'd93: u = mk(OP_DIV,    S_T5,  S_T2,   D_NONE, '0);
            7'd94: u = mk(OP_ADD,    S_Q,   S_T3,   D_SR,  '0);
            7'd95: u = mk(OP_END_RES, S_ZERO, S_ZERO, D_NONE, '0);
            7'd96: u = mk(OP_END_NOFIT, S_ZERO, S_ZERO, D_NONE, '0);
            default: u = mk(OP_END, S_ZERO, S_ZERO, D_NONE, '0);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/wtlf_mul.sv
// Signed 64 x 64 multiplier built from four 32 x 32 partial products over cycles.
// Depends on wtlf_pkg.
`timescale 1ns / 1ps

module wtlf_mul
    import wtlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output wide_t              prod
);

    logic        run_reg, run_next;
    logic [2:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg;
    logic [63:0] pp_reg;
    logic [1:0]  sh_reg;
    wide_t       acc_reg, prod_reg;
    logic [31:0] pa, pb;
    wide_t       pp_shift;

    assign pa = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign pb = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd5)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'(-a) : a;
            mb_reg  <= b[63] ? 64'(-b) : b;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (step_reg < 3'd4)
            begin
                pp_reg <= pa * pb;
                sh_reg <= 2'(step_reg[1] + step_reg[0]);
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
                acc_reg <= acc_reg + pp_shift;
            if (step_reg == 3'd5)
                prod_reg <= neg_reg ? -acc_reg : acc_reg;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: rtl/wtlf_div.sv
// Signed floor divider on 128-bit words, restoring, one quotient bit per cycle.
// Depends on wtlf_pkg.
`timescale 1ns / 1ps

module wtlf_div
    import wtlf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t a,
    input  wide_t b,
    output logic  done,
    output wide_t quo
);

    localparam int CW = $clog2(VW);

    logic          run_reg, run_next;
    logic          fix_reg, fix_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] r_reg, q_reg, mb_reg;
    logic          na_reg, nb_reg;
    wide_t         quo_reg;
    logic [VW-1:0] r_sh;
    logic [VW:0]   diff;
    logic          ge;

    assign r_sh = {r_reg[VW-2:0], q_reg[VW-1]};
    assign diff = {1'b0, r_sh} - {1'b0, mb_reg};
    assign ge   = !diff[VW];

    always_comb
    begin
        run_next  = run_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg)
            begin
                run_next = 1'b0;
                fix_next = 1'b1;
            end
        end
        else if (fix_reg)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg  <= a[VW-1] ? -a : a;
            mb_reg <= b[VW-1] ? -b : b;
            na_reg <= a[VW-1];
            nb_reg <= b[VW-1];
            r_reg  <= '0;
        end
        else if (run_reg)
        begin
            q_reg <= {q_reg[VW-2:0], ge};
            r_reg <= ge ? diff[VW-1:0] : r_sh;
        end
        else if (fix_reg)
        begin
            // floor towards minus infinity when signs differ
            if (na_reg != nb_reg)
                quo_reg <= (|r_reg) ? ~q_reg : -q_reg;
            else
                quo_reg <= q_reg;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/wtlf_dp.sv
// Datapath: fit sums, origin, configuration, temporaries, shared multiplier and divider.
// Depends on wtlf_pkg, wtlf_mul and wtlf_div.
`timescale 1ns / 1ps

module wtlf_dp
    import wtlf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         func,
    input  logic signed [31:0] sample_index,
    input  logic signed [31:0] time_value,
    output logic signed [31:0] time_result,
    output logic signed [31:0] sample_result,
    output logic [15:0]        sample_fraction,
    output logic               fit_status
);

    localparam int F = FRACTION_BITS;

    logic [15:0]        dr_reg;
    logic [9:0]         period_reg;
    logic [9:0]         cnt_reg;
    logic [31:0]        w_reg;
    logic signed [47:0] sx_reg, st_reg;
    logic signed [63:0] sxx_reg, sxt_reg;
    logic [31:0]        ox_reg, ot_reg;

    logic [1:0]         func_reg;
    logic [31:0]        x_reg, y_reg;
    wide_t              t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [31:0]        tr_reg, sr_reg;
    logic [15:0]        sf_reg;

    logic [31:0]        xd, yd;
    wide_t              a_val, b_val, res, res_sar;
    wide_t              prod, quo;
    logic               mul_done, div_done;
    logic signed [31:0] s32;
    logic signed [63:0] s64;
    logic [F+15:0]      frac_x;
    logic               do_exec;
    op_t                op;

    assign op      = cmd.uw.op;
    assign do_exec = cmd.exec;
    assign xd      = x_reg - ox_reg;
    assign yd      = y_reg - ot_reg;

    function automatic wide_t pick(src_t s, logic [31:0] xdv, logic [31:0] ydv,
                                   wide_t p, wide_t q, logic [31:0] w,
                                   logic signed [47:0] sx, logic signed [47:0] st,
                                   logic signed [63:0] sxx, logic signed [63:0] sxt,
                                   logic [15:0] dr, wide_t t0, wide_t t1, wide_t t2,
                                   wide_t t3, wide_t t4, wide_t t5);
        wide_t v;
        case (s)
            S_W:     v = {96'd0, w};
            S_SX:    v = {{80{sx[47]}}, sx};
            S_ST:    v = {{80{st[47]}}, st};
            S_SXX:   v = {{64{sxx[63]}}, sxx};
            S_SXT:   v = {{64{sxt[63]}}, sxt};
            S_XV:    v = {{96{xdv[31]}}, xdv};
            S_YV:    v = {{96{ydv[31]}}, ydv};
            S_DR:    v = {112'd0, dr};
            S_ONE:   v = wide_t'(1) << F;
            S_T0:    v = t0;
            S_T1:    v = t1;
            S_T2:    v = t2;
            S_T3:    v = t3;
            S_T4:    v = t4;
            S_T5:    v = t5;
            S_P:     v = p;
            S_Q:     v = q;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign a_val = pick(cmd.uw.a, xd, yd, prod, quo, w_reg, sx_reg, st_reg, sxx_reg,
                        sxt_reg, dr_reg, t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg);
    assign b_val = pick(cmd.uw.b, xd, yd, prod, quo, w_reg, sx_reg, st_reg, sxx_reg,
                        sxt_reg, dr_reg, t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg);

    assign s32 = sat32(a_val);
    assign s64 = sat64(a_val);

    always_comb
    begin
        case (op)
            OP_PASS:  res = a_val;
            OP_ADD:   res = a_val + b_val;
            OP_SUB:   res = a_val - b_val;
            OP_SHLF:  res = a_val <<< F;
            OP_SARF:  res = a_val >>> F;
            OP_SAR16: res = a_val >>> 16;
            OP_SHL1:  res = a_val <<< 1;
            OP_SAT32: res = {{96{s32[31]}}, s32};
            OP_SAT64: res = {{64{s64[63]}}, s64};
            default:  res = '0;
        endcase
    end

    assign res_sar = res >>> F;
    assign frac_x  = {res[F-1:0], 16'd0};

    wtlf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (do_exec && op == OP_MUL),
        .a     (a_val[63:0]),
        .b     (b_val[63:0]),
        .done  (mul_done),
        .prod  (prod)
    );

    wtlf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (do_exec && op == OP_DIV),
        .a     (a_val),
        .b     (b_val),
        .done  (div_done),
        .quo   (quo)
    );

    assign stat.a_zero    = (a_val == '0);
    assign stat.cnt_lt    = (cnt_reg < period_reg);
    assign stat.sample_q  = (func_reg == FUNC_SAMPLE);
    assign stat.unit_done = mul_done | div_done;

    // fit state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dr_reg     <= 16'd655;
            period_reg <= 10'd100;
            cnt_reg    <= '0;
            w_reg      <= '0;
            sx_reg     <= '0;
            st_reg     <= '0;
            sxx_reg    <= '0;
            sxt_reg    <= '0;
            ox_reg     <= '0;
            ot_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index[1] == 1'b0)
            begin
                if (cfg_index[0] == CFG_DECAY)
                    dr_reg <= cfg_data;
                else
                    period_reg <= cfg_data[9:0];
            end
            if (do_exec)
            begin
                if (op == OP_CNTINC)
                    cnt_reg <= cnt_reg + 10'd1;
                else if (op == OP_CNTCLR)
                    cnt_reg <= '0;
                case (cmd.uw.dst)
                    D_W:     w_reg   <= satu32(res);
                    D_SX:    sx_reg  <= sat48(res);
                    D_ST:    st_reg  <= sat48(res);
                    D_SXX:   sxx_reg <= sat64(res);
                    D_SXT:   sxt_reg <= sat64(res);
                    D_OX:    ox_reg  <= ox_reg + res[31:0];
                    D_OT:    ot_reg  <= ot_reg + res[31:0];
                    default: ;
                endcase
            end
        end
    end

    // word latch, temporaries and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            func_reg <= func;
            x_reg    <= sample_index;
            y_reg    <= time_value;
        end
        if (do_exec)
        begin
            case (cmd.uw.dst)
                D_T0:    t0_reg <= res;
                D_T1:    t1_reg <= res;
                D_T2:    t2_reg <= res;
                D_T3:    t3_reg <= res;
                D_T4:    t4_reg <= res;
                D_T5:    t5_reg <= res;
                D_TR:    tr_reg <= ot_reg + res_sar[31:0];
                D_SR:
                begin
                    sr_reg <= ox_reg + res_sar[31:0];
                    sf_reg <= frac_x[F+15:F];
                end
                default: ;
            endcase
            if (op == OP_END_RES)
            begin
                time_result     <= (func_reg == FUNC_TIME) ? tr_reg : 32'd0;
                sample_result   <= (func_reg == FUNC_SAMPLE) ? sr_reg : 32'd0;
                sample_fraction <= (func_reg == FUNC_SAMPLE) ? sf_reg : 16'd0;
                fit_status      <= 1'b0;
            end
            else if (op == OP_END_NOFIT)
            begin
                time_result     <= '0;
                sample_result   <= '0;
                sample_fraction <= '0;
                fit_status      <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/wtlf_ctrl.sv
// Controller: input handshake, program counter and sequencing, output valid.
// Depends on wtlf_pkg.
`timescale 1ns / 1ps

module wtlf_ctrl
    import wtlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    output logic       out_valid,
    input  logic       out_ready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;
    logic   out_valid_reg, out_valid_next;
    uword_t uw;
    logic   blocked;
    logic   is_out;
    logic   accept;

    assign uw       = ucode(pc_reg);
    assign blocked  = out_valid_reg && !out_ready;
    assign is_out   = (uw.op == OP_END_RES) || (uw.op == OP_END_NOFIT);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign cmd.uw      = uw;
    assign cmd.in_load = accept;
    assign cmd.exec    = (state_reg == ST_EXEC) && !(is_out && blocked);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func != FUNC_NONE)
                begin
                    state_next = ST_EXEC;
                    pc_next    = (func == FUNC_OBSERVE) ? PC_OBS : PC_QUERY;
                end
            end
            ST_EXEC:
            begin
                case (uw.op)
                    OP_MUL, OP_DIV:
                    begin
                        state_next = ST_WAIT;
                        pc_next    = pc_reg + 1'b1;
                    end
                    OP_BRZ:    pc_next = stat.a_zero ? uw.tgt : pc_reg + 1'b1;
                    OP_BRNZ:   pc_next = !stat.a_zero ? uw.tgt : pc_reg + 1'b1;
                    OP_BRLT:   pc_next = stat.cnt_lt ? uw.tgt : pc_reg + 1'b1;
                    OP_BRSAMP: pc_next = stat.sample_q ? uw.tgt : pc_reg + 1'b1;
                    OP_END:    state_next = ST_IDLE;
                    OP_END_RES, OP_END_NOFIT:
                    begin
                        // hold until the previous word has gone
                        if (!blocked)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:   pc_next = pc_reg + 1'b1;
                endcase
            end
            ST_WAIT:
            begin
                if (stat.unit_done)
                    state_next = ST_EXEC;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/weighted_time_line_fitter_core.sv
// Exponentially weighted line fit from sample index to timestamp.
// An observe word updates the sums; once the word counter reaches recenter_period, the origin is moved to the mean.
// Time and sample queries fit the line from the sums; one word is taken at a time.
// Reset (asynchronous, active low) clears the sums, origin and counter and loads
// decay_rate 655 and recenter_period 100; a result may wait while the next word is taken.
`timescale 1ns / 1ps

module weighted_time_line_fitter_core
    import wtlf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] sample_index,
    input  logic signed [31:0] time_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] time_result,
    output logic signed [31:0] sample_result,
    output logic [15:0]        sample_fraction,
    output logic               fit_status
);

    cmd_t  cmd;
    stat_t stat;

    wtlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wtlf_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .sample_index    (sample_index),
        .time_value      (time_value),
        .time_result     (time_result),
        .sample_result   (sample_result),
        .sample_fraction (sample_fraction),
        .fit_status      (fit_status)
    );

endmodule
